// ----- rtl/fsle_pkg.sv -----
// Shared types, constants and tap helpers for the same-length correlation filter.
package fsle_pkg;

  localparam int NUM_COEFS   = 6;
  localparam int COEF_W      = 16;
  localparam int OUT_W       = 34;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TAPS_W      = 3;
  localparam int D_W         = 2;
  localparam int SEEN_CLIP_W = 3;
  localparam int JOB_DEPTH   = 4;
  localparam int JOB_PTR_W   = 2;
  localparam int JOB_CNT_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAD_MODE  = 3'd0,
    REG_TAP_COUNT = 3'd1,
    REG_COEF_0    = 3'd2,
    REG_COEF_1    = 3'd3,
    REG_COEF_2    = 3'd4,
    REG_COEF_3    = 3'd5,
    REG_COEF_4    = 3'd6,
    REG_COEF_5    = 3'd7
  } cfg_reg_t;

  // One queued job: results for window offsets d_hi down to d_lo.
  typedef struct packed {
    logic [D_W-1:0]         d_hi;
    logic [D_W-1:0]         d_lo;
    logic                   last;
    logic [SEEN_CLIP_W-1:0] seen;
  } job_ctl_t;

  // Tap count in use: zero counts as one, and it is capped at lim.
  function automatic logic [TAPS_W-1:0] eff_taps(input logic [TAPS_W-1:0] tc,
                                                 input logic [TAPS_W-1:0] lim);
    logic [TAPS_W-1:0] t;
    t = tc;
    if (t == '0) t = TAPS_W'(1);
    if (t > lim) t = lim;
    return t;
  endfunction

  function automatic logic [D_W-1:0] shift_of(input logic [TAPS_W-1:0] taps);
    return D_W'(taps >> 1);
  endfunction

  function automatic logic [D_W-1:0] lag_of(input logic [TAPS_W-1:0] taps);
    logic [TAPS_W-1:0] l;
    l = taps - TAPS_W'(1) - (taps >> 1);
    return D_W'(l);
  endfunction

endpackage

// ----- rtl/fsle_front.sv -----
// Front end: keeps the sample window and turns each item into a queued job.
module fsle_front #(
  parameter int MAX_TAPS    = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         accept,
  input  logic signed [SAMPLE_BITS-1:0]                sample,
  input  logic                                         last_sample,
  input  logic [fsle_pkg::TAPS_W-1:0]                  taps,
  output logic                                         push,
  output fsle_pkg::job_ctl_t                           job_ctl,
  output logic [(fsle_pkg::NUM_COEFS+1)*SAMPLE_BITS-1:0] job_samples
);
  import fsle_pkg::*;

  localparam int SEEN_W = $clog2(MAX_TAPS + 1);

  logic signed [SAMPLE_BITS-1:0] window      [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] window_next [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] first;
  logic signed [SAMPLE_BITS-1:0] first_next;
  logic [SEEN_W-1:0]             seen;
  logic [SEEN_W-1:0]             seen_next;
  logic [D_W-1:0]                lag;
  int                            cnt;

  always_comb begin
    seen_next  = (int'(seen) < MAX_TAPS) ? seen + SEEN_W'(1) : seen;
    first_next = (seen == '0) ? sample : first;
    window_next[0] = sample;
    for (int j = 1; j < MAX_TAPS; j++) begin
      window_next[j] = window[j-1];
    end
    lag = lag_of(taps);
    cnt = (int'(seen_next) < int'(lag) + 1) ? int'(seen_next) : int'(lag) + 1;

    job_ctl.seen = (int'(seen_next) > 7) ? SEEN_CLIP_W'(7) : SEEN_CLIP_W'(seen_next);
    if (last_sample) begin
      // The last item flushes every output still owed, newest offset last.
      push         = accept;
      job_ctl.d_hi = D_W'(cnt - 1);
      job_ctl.d_lo = '0;
      job_ctl.last = 1'b1;
    end else begin
      push         = accept && (int'(seen_next) > int'(lag));
      job_ctl.d_hi = lag;
      job_ctl.d_lo = lag;
      job_ctl.last = 1'b0;
    end

    job_samples = '0;
    for (int j = 0; j < NUM_COEFS; j++) begin
      if (j < MAX_TAPS) begin
        job_samples[j*SAMPLE_BITS +: SAMPLE_BITS] = window_next[j];
      end
    end
    job_samples[NUM_COEFS*SAMPLE_BITS +: SAMPLE_BITS] = first_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= last_sample ? '0 : seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first <= first_next;
      for (int j = 0; j < MAX_TAPS; j++) begin
        window[j] <= window_next[j];
      end
    end
  end

endmodule

// ----- rtl/fsle_queue.sv -----
// Short job queue that decouples the front end from the multiply-add back end.
module fsle_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  import fsle_pkg::*;

  logic [W-1:0]         mem [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr;
  logic [JOB_PTR_W-1:0] rd_ptr;
  logic [JOB_CNT_W-1:0] count;

  assign full       = (count == JOB_CNT_W'(JOB_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + JOB_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + JOB_PTR_W'(1);
      if (push && !pop) begin
        count <= count + JOB_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - JOB_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= JOB_CNT_W'(JOB_DEPTH))
    else $error("job queue count out of range");
`endif

endmodule

// ----- rtl/fsle_back.sv -----
// Back end: steps through each job's offsets, multiplies all taps and sums.
module fsle_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           job_valid,
  input  fsle_pkg::job_ctl_t                             job_ctl,
  input  logic [(fsle_pkg::NUM_COEFS+1)*SAMPLE_BITS-1:0] job_samples,
  input  logic [fsle_pkg::TAPS_W-1:0]                    taps,
  input  logic                                           pad_mode,
  input  logic signed [fsle_pkg::COEF_W-1:0]             coef [fsle_pkg::NUM_COEFS],
  output logic                                           pop,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic signed [fsle_pkg::OUT_W-1:0]              filtered,
  output logic                                           last_result
);
  import fsle_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int SUM_W  = PROD_W + 3;

  logic                          en;
  logic                          issue;
  logic                          at_end;
  logic [D_W-1:0]                d_off;
  logic [D_W-1:0]                d;
  logic [D_W-1:0]                shift;
  logic signed [SAMPLE_BITS-1:0] win [NUM_COEFS];
  logic signed [SAMPLE_BITS-1:0] first;
  logic signed [SAMPLE_BITS-1:0] v;
  logic signed [3:0]             p;
  logic signed [PROD_W-1:0]      prod_next [NUM_COEFS];
  logic signed [PROD_W-1:0]      s1_prod   [NUM_COEFS];
  logic                          s1_valid;
  logic                          s1_last;
  logic signed [SUM_W-1:0]       sum;

  // The whole pipe advances unless a finished result is waiting downstream.
  assign en     = !out_valid || out_ready;
  assign issue  = job_valid && en;
  assign d      = job_ctl.d_hi - d_off;
  assign at_end = (d == job_ctl.d_lo);
  assign pop    = issue && at_end;
  assign shift  = shift_of(taps);

  always_comb begin
    for (int j = 0; j < NUM_COEFS; j++) begin
      win[j] = job_samples[j*SAMPLE_BITS +: SAMPLE_BITS];
    end
    first = job_samples[NUM_COEFS*SAMPLE_BITS +: SAMPLE_BITS];
    v     = '0;
    p     = '0;
    for (int k = 0; k < NUM_COEFS; k++) begin
      p = signed'(4'(d) + 4'(shift) - 4'(k));
      // Past the newest sample reads the newest one; before the first, the first; zero padding reads zero.
      if (k >= int'(taps)) begin
        v = '0;
      end else if (p < 0) begin
        v = pad_mode ? '0 : win[0];
      end else if (p[2:0] >= job_ctl.seen) begin
        v = pad_mode ? '0 : first;
      end else begin
        v = win[p[2:0]];
      end
      prod_next[k] = PROD_W'(v) * PROD_W'(coef[k]);
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_COEFS; k++) begin
      sum = sum + SUM_W'(s1_prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_off     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) d_off <= at_end ? '0 : d_off + D_W'(1);
      if (en) begin
        s1_valid  <= issue;
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_COEFS; k++) begin
        s1_prod[k] <= prod_next[k];
      end
      s1_last     <= job_ctl.last && (d == '0);
      filtered    <= OUT_W'(sum);
      last_result <= s1_last;
    end
  end

`ifndef SYNTHESIS
  a_off_bound: assert property (@(posedge clk) disable iff (rst)
                                job_valid |-> d_off <= job_ctl.d_hi - job_ctl.d_lo)
    else $error("offset counter ran past the job");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
                              s1_valid && !en |=> s1_valid)
    else $error("product stage dropped an item while stalled");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst) !en |-> !pop)
    else $error("job retired while the pipe was stalled");
`endif

endmodule

// ----- rtl/fir_same_length_edge_pad_unit.sv -----
// Top level of the same-length correlation filter with zero or edge padding.
//
//  channel | direction | handshake           | contents
//  s_      | in        | s_tvalid / s_tready | tdata: sample; tlast: last_sample
//  m_      | out       | m_tvalid / m_tready | tdata: filtered; tlast: last_result
//  cfg_    | in        | cfg_we              | cfg_index, cfg_data
//
// One item per cycle in while s_tready is high; each non-last item yields at most
// one result, and the last item of a vector yields up to three, which the back end
// issues one per cycle while m_ is not stalled, from a four-entry job queue. A result
// passes through the job queue, the product register and then the output register
// before it is offered on m_. Reset is synchronous; it empties the queue and the
// pipe and loads the register defaults. A stall on m_ backs up into the queue, and
// s_tready falls only when the queue is full.
module fir_same_length_edge_pad_unit #(
  parameter int MAX_TAPS    = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [fsle_pkg::OUT_TDATA_W-1:0]     m_tdata,   // filtered
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [fsle_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsle_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fsle_pkg::*;

  localparam int TAP_LIM = (MAX_TAPS < NUM_COEFS) ? MAX_TAPS : NUM_COEFS;
  localparam int SAMP_W  = (NUM_COEFS + 1) * SAMPLE_BITS;
  localparam int JOB_W   = $bits(job_ctl_t) + SAMP_W;

  logic                      pad_mode;
  logic [TAPS_W-1:0]         tap_count;
  logic signed [COEF_W-1:0]  coef [NUM_COEFS];
  logic [TAPS_W-1:0]         taps;
  logic                      accept;
  logic                      push;
  logic                      pop;
  logic                      full;
  logic                      head_valid;
  job_ctl_t                  front_ctl;
  job_ctl_t                  head_ctl;
  logic [SAMP_W-1:0]         front_samples;
  logic [SAMP_W-1:0]         head_samples;
  logic [JOB_W-1:0]          head_data;
  logic signed [OUT_W-1:0]   filtered;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mode  <= 1'b1;
      tap_count <= TAPS_W'(1);
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef[k] <= '0;
      end
      coef[0] <= COEF_W'(16384);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAD_MODE:  pad_mode  <= cfg_data[0];
        REG_TAP_COUNT: tap_count <= cfg_data[TAPS_W-1:0];
        default:       coef[CFG_IDX_W'(cfg_index - REG_COEF_0)] <= cfg_data;
      endcase
    end
  end

  assign taps     = eff_taps(tap_count, TAPS_W'(TAP_LIM));
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  fsle_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (s_tdata[SAMPLE_BITS-1:0]),
    .last_sample (s_tlast),
    .taps        (taps),
    .push        (push),
    .job_ctl     (front_ctl),
    .job_samples (front_samples)
  );

  fsle_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({front_ctl, front_samples}),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_ctl     = head_data[JOB_W-1 -: $bits(job_ctl_t)];
  assign head_samples = head_data[SAMP_W-1:0];

  fsle_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (head_valid),
    .job_ctl     (head_ctl),
    .job_samples (head_samples),
    .taps        (taps),
    .pad_mode    (pad_mode),
    .coef        (coef),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .filtered    (filtered),
    .last_result (m_tlast)
  );

  assign m_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, filtered};

endmodule

// ----- test/tb_fir_same_length_edge_pad_unit.sv -----
// Self-checking testbench for the same-length correlation filter with zero or edge padding.
`timescale 1ns / 1ps

module tb_fir_same_length_edge_pad_unit;
  import fsle_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] sum;
    logic                    last;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;  // sample
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;  // filtered
  logic m_tlast;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_PAD_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block: configuration and the state of the current vector.
  bit pad_zero;
  logic [2:0] tap_reg;
  logic signed [15:0] coef [NUM_COEFS];
  logic signed [15:0] window [6];
  logic signed [15:0] first_x;
  int seen;

  corr_result_t owed_results[$];
  int errors = 0;
  bit idle_en = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  fir_same_length_edge_pad_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Sum for the output that sits d positions behind the newest sample.
  function automatic logic signed [OUT_W-1:0] window_sum(int taps, int shift, int d);
    longint acc;
    longint v;
    int p;
    acc = 0;
    for (int k = 0; k < taps; k++) begin
      p = d - k + shift;
      if (p < 0) begin
        v = pad_zero ? 64'sd0 : longint'(window[0]);
      end else if (p >= seen || p >= 6) begin
        v = pad_zero ? 64'sd0 : longint'(first_x);
      end else begin
        v = longint'(window[p]);
      end
      acc += v * longint'(coef[k]);
    end
    return acc[OUT_W-1:0];
  endfunction

  function automatic void push_result(logic signed [OUT_W-1:0] sum, logic last);
    corr_result_t r;
    r.sum = sum;
    r.last = last;
    owed_results.insert(owed_results.size(), r);
  endfunction

  function automatic void predict_sample(logic signed [15:0] x, logic last);
    int taps;
    int shift;
    int lag;
    int cnt;
    taps = tap_reg;
    if (taps < 1) taps = 1;
    if (taps > 6) taps = 6;
    shift = taps / 2;
    lag = taps - 1 - shift;
    if (seen == 0) first_x = x;
    for (int k = 5; k > 0; k--) window[k] = window[k-1];
    window[0] = x;
    if (seen < 6) seen++;
    if (!last) begin
      if (seen > lag) push_result(window_sum(taps, shift, lag), 1'b0);
    end else begin
      cnt = (seen < lag + 1) ? seen : lag + 1;
      for (int d = cnt - 1; d >= 0; d--) push_result(window_sum(taps, shift, d), d == 0);
      foreach (window[k]) window[k] = '0;
      first_x = '0;
      seen = 0;
    end
  endfunction

  // Sender: optional gap, then offer the item until it is taken.
  task automatic send_sample(logic signed [15:0] x, logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_sample(x, last);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PAD_MODE: pad_zero = val[0];
      REG_TAP_COUNT: tap_reg = val[2:0];
      default: coef[idx - REG_COEF_0] = val;
    endcase
    @(posedge clk);
  endtask

  // Stop offering, let every owed result out, then let the pipe settle.
  task automatic drain_filter();
    s_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic randomize_config();
    write_reg(REG_PAD_MODE, 16'($urandom_range(0, 1)));
    write_reg(REG_TAP_COUNT, 16'($urandom_range(0, 7)));
    for (int k = 0; k < NUM_COEFS; k++) write_reg(cfg_reg_t'(REG_COEF_0 + k), rand_value());
  endtask

  // Receiver: random stall bursts, plus a long hold when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: filtered=%0d last=%0b",
                                   $signed(m_tdata[OUT_W-1:0]), m_tlast);
      end else begin
        if (m_tdata[OUT_W-1:0] !== owed_results[0].sum || m_tlast !== owed_results[0].last)
        begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: filtered exp %0d got %0d, last exp %0b got %0b",
                     $time, owed_results[0].sum, $signed(m_tdata[OUT_W-1:0]),
                     owed_results[0].last, m_tlast);
        end
        void'(owed_results.pop_front());
      end
    end
  end

  task automatic send_vector(logic signed [15:0] xs[$]);
    foreach (xs[i]) send_sample(xs[i], i == xs.size() - 1);
  endtask

  task automatic test_reset_defaults();
    send_vector('{16'sh7fff, 16'sh8000, 16'sh0001});
    send_vector('{16'shffff});
    drain_filter();
  endtask

  task automatic test_extreme_config();
    write_reg(REG_PAD_MODE, 16'd0);
    write_reg(REG_TAP_COUNT, 16'd6);
    for (int k = 0; k < NUM_COEFS; k++)
      write_reg(cfg_reg_t'(REG_COEF_0 + k), (k % 2) ? 16'h7fff : 16'h8000);
    send_vector('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    drain_filter();
    write_reg(REG_PAD_MODE, 16'd1);
    send_vector('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    drain_filter();
  endtask

  // A tap count of zero acts as one tap; seven is held to the window size.
  task automatic test_tap_count_limits();
    write_reg(REG_TAP_COUNT, 16'd0);
    send_vector('{16'sh1234, 16'shedcb});
    drain_filter();
    write_reg(REG_TAP_COUNT, 16'd7);
    write_reg(REG_PAD_MODE, 16'd0);
    send_vector('{16'sh4000, 16'shc000, 16'sh0fff});
    drain_filter();
  endtask

  // Tap count and pad mode change halfway through a vector.
  task automatic test_mid_vector_change();
    write_reg(REG_TAP_COUNT, 16'd2);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    drain_filter();
    write_reg(REG_TAP_COUNT, 16'd5);
    write_reg(REG_PAD_MODE, 16'd1);
    send_sample(16'shff00, 1'b0);
    send_sample(16'sh0033, 1'b1);
    drain_filter();
  endtask

  // The receiver holds off while items keep coming, so the input must stall.
  task automatic test_output_backpressure();
    write_reg(REG_TAP_COUNT, 16'd6);
    write_reg(REG_PAD_MODE, 16'd0);
    idle_en = 1'b0;
    hold_left = 60;
    for (int i = 0; i < 20; i++) send_sample(rand_value(), i == 19);
    drain_filter();
    idle_en = 1'b1;
  endtask

  task automatic test_random_vectors();
    int len;
    int sent;
    sent = 0;
    while (sent < 215) begin
      if (sent < 175 && $urandom_range(0, 2) == 0) begin
        drain_filter();
        randomize_config();
      end
      idle_en = (sent < 175) && ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (sent < 175 && i == len / 2 && len > 3 && $urandom_range(0, 9) == 0) begin
          drain_filter();
          write_reg(REG_TAP_COUNT, 16'($urandom_range(0, 7)));
        end
        send_sample(rand_value(), i == len - 1);
        sent++;
      end
    end
    idle_en = 1'b0;
  endtask

  initial begin
    pad_zero = 1'b1;
    tap_reg = 3'd1;
    foreach (coef[k]) coef[k] = '0;
    coef[0] = 16'sd16384;
    foreach (window[k]) window[k] = '0;
    first_x = '0;
    seen = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_config();
    test_tap_count_limits();
    test_mid_vector_change();
    test_output_backpressure();
    test_random_vectors();
    drain_filter();
    repeat (10) @(posedge clk);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
